// ===== rtl/tss_pkg.sv =====
// Package for the tridiagonal system solver: payload structs, status codes,
// and Q16.16 helper functions. No dependencies.
`default_nettype none
package tss_pkg;
    localparam int MaxRowsDefault = 64;
    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StZeroFirst = 2'd1;
    localparam logic [1:0] StZeroLater = 2'd2;
    localparam logic [1:0] StTooMany = 2'd3;

    typedef struct packed {
        logic signed [31:0] coef_sub;
        logic signed [31:0] coef_diag;
        logic signed [31:0] coef_super;
        logic signed [31:0] rhs;
        logic               last_row;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] solution;
        logic [5:0]         row_index;
        logic [1:0]         status;
        logic               last_result;
    } t_out_word;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Round a 64-bit product to Q16.16, ties toward plus infinity.
    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd32768) >>> 16;
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        return sat32(64'(x) - 64'(y));
    endfunction
endpackage
`default_nettype wire

// ===== rtl/tridiagonal_system_solver.sv =====
// Top level of the tridiagonal system solver (Thomas algorithm, Q16.16).
// Depends on tss_pkg.
//
// Rows arrive one word at a time; forward elimination runs on each row and
// the last row starts back substitution, whose results leave last row first.
// A shared restoring divider takes one quotient bit per cycle (49 bits), with
// a setup step before and a finish step after. One shared 32x32 multiplier
// is registered before use. The first row of a system takes one division,
// and a later row takes two divisions and two products.
// Back substitution is interleaved with the output: after its division
// ends, the top row's word is read out through S_B_RD and S_OUT_RD, and each
// further word is computed in S_B_RD, S_B_MUL and S_B_WR after the previous
// handshake. The block accepts no row while it is working or while results
// are being delivered. A zero first diagonal or an overlong system yields
// one error word when the last row arrives.
`default_nettype none
module tridiagonal_system_solver
    import tss_pkg::*;
#(
    parameter int MAX_ROWS = MaxRowsDefault
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    output logic          o_valid,
    input  wire           i_ready,
    output t_out_word     o_data
);
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_G_DIV = 4'd1;   // gamma = prev_super / pivot
    localparam logic [3:0] S_MUL1 = 4'd2;    // a * gamma
    localparam logic [3:0] S_MUL2 = 4'd3;    // a * u[j-1]
    localparam logic [3:0] S_U_DIV = 4'd4;   // u = (r - a u) / pivot
    localparam logic [3:0] S_ERR = 4'd5;
    localparam logic [3:0] S_B_RD = 4'd6;
    localparam logic [3:0] S_B_MUL = 4'd7;
    localparam logic [3:0] S_B_WR = 4'd8;
    localparam logic [3:0] S_OUT_RD = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;
    localparam logic [3:0] S_LDPREV = 4'd11;
    localparam logic [3:0] S_DIVW = 4'd12;

    logic [3:0] r_state, r_ret;
    logic signed [31:0] r_gam_mem [MAX_ROWS];
    logic signed [31:0] r_u_mem [MAX_ROWS];
    logic signed [31:0] r_pivot, r_prev_super, r_a, r_b, r_r, r_gamma, r_uprev;
    logic signed [31:0] r_gam_rd, r_u_rd, r_unext, r_tmp;
    logic [CW-1:0] r_count;
    logic [1:0] r_err;
    logic r_last;
    logic [AW-1:0] r_j;
    logic signed [63:0] r_prod;

    // Divider: |num| << 17 plus |den|, over 2|den|, restoring, 49 bits.
    logic [48:0] r_dq;
    logic [33:0] r_drem, r_dden;
    logic [5:0] r_dcnt;
    logic r_dneg, r_dzero;
    logic signed [31:0] r_dnum;
    logic signed [31:0] w_dres;
    logic [34:0] w_trial;

    logic signed [31:0] w_mul_x, w_mul_y;
    logic signed [31:0] w_pq, w_bet, w_qsat;
    logic [AW-1:0] w_cidx;
    logic signed [63:0] w_qs;

    assign w_cidx = r_count[AW-1:0];
    assign w_pq = qround(r_prod);
    assign w_bet = qsub(r_b, r_tmp);
    assign w_trial = {r_drem, r_dq[48]} - {1'b0, r_dden};
    assign w_qs = r_dneg ? -$signed({15'd0, r_dq}) : $signed({15'd0, r_dq});
    assign w_qsat = sat32(w_qs);
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        w_mul_x = r_a;
        w_mul_y = r_gamma;
        unique case (r_state)
            S_MUL2: w_mul_y = r_uprev;
            S_B_MUL: begin
                w_mul_x = r_gam_rd;
                w_mul_y = r_unext;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_G_DIV && r_dcnt == 6'd0) r_gam_mem[w_cidx] <= r_gamma;
        if (r_state == S_DIVW && r_ret == S_IDLE && r_dcnt == 6'd49)
            r_u_mem[r_j] <= w_dres;
        r_gam_rd <= r_gam_mem[r_j + AW'(1)];
        r_u_rd <= r_u_mem[r_j];
        r_prod <= w_mul_x * w_mul_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_err <= StOk;
            r_pivot <= '0;
            r_prev_super <= '0;
            o_valid <= 1'b0;
            r_dcnt <= '0;
            r_ret <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_a <= i_data.coef_sub;
                    r_b <= i_data.coef_diag;
                    r_r <= i_data.rhs;
                    r_last <= i_data.last_row;
                    if (r_err == StZeroFirst) begin
                        r_state <= i_data.last_row ? S_ERR : S_IDLE;
                    end else if (r_count >= CW'(MAX_ROWS)) begin
                        r_err <= StTooMany;
                        r_state <= i_data.last_row ? S_ERR : S_IDLE;
                    end else if (r_count == '0) begin
                        if (i_data.coef_diag == 0) begin
                            r_err <= StZeroFirst;
                            r_state <= i_data.last_row ? S_ERR : S_IDLE;
                        end else begin
                            r_pivot <= i_data.coef_diag;
                            r_prev_super <= i_data.coef_super;
                            r_dnum <= i_data.rhs;
                            r_dden <= {2'b0, i_data.coef_diag[31] ?
                                      -i_data.coef_diag : i_data.coef_diag} << 1;
                            r_dzero <= 1'b0;
                            r_j <= '0;
                            r_ret <= S_IDLE;
                            r_state <= S_DIVW;
                            r_dcnt <= 6'd63;
                        end
                    end else begin
                        r_prev_super <= i_data.coef_super;
                        r_dnum <= r_prev_super;
                        r_dden <= {2'b0, r_pivot[31] ? -r_pivot : r_pivot} << 1;
                        r_dzero <= (r_pivot == 0);
                        r_j <= AW'(r_count - CW'(1));
                        r_ret <= S_G_DIV;
                        r_state <= S_LDPREV;
                    end
                end
                S_LDPREV: begin
                    // u[j-1] available from the registered read
                    r_uprev <= r_u_rd;
                    r_dneg <= r_dnum[31] ^ r_pivot[31];
                    r_dq <= {r_dnum[31] ? -r_dnum : r_dnum, 17'd0} + 49'(r_dden >> 1);
                    r_drem <= '0;
                    r_dcnt <= '0;
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (r_dcnt == 6'd63) begin
                        // setup for a u division (the gamma division sets up in S_LDPREV)
                        r_dneg <= r_dnum[31] ^ r_pivot[31];
                        r_dq <= {r_dnum[31] ? -r_dnum : r_dnum, 17'd0}
                                + 49'(r_dden >> 1);
                        r_drem <= '0;
                        r_dcnt <= '0;
                    end else if (r_dcnt < 6'd49) begin
                        if (!w_trial[34]) begin
                            r_drem <= w_trial[33:0];
                            r_dq <= {r_dq[47:0], 1'b1};
                        end else begin
                            r_drem <= {r_drem[32:0], r_dq[48]};
                            r_dq <= {r_dq[47:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt + 6'd1;
                    end else begin
                        r_dcnt <= 6'd0;
                        if (r_ret == S_G_DIV) begin
                            r_gamma <= w_dres;
                            r_state <= S_G_DIV;
                        end else begin
                            // u is written above and r_j still points at this
                            // row, which is the top row when it is the last.
                            r_count <= r_count + CW'(1);
                            r_state <= r_last ? S_B_RD : S_IDLE;
                        end
                    end
                end
                S_G_DIV: r_state <= S_MUL1;
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_tmp <= w_pq;          // a*gamma
                    r_state <= S_U_DIV;
                end
                S_U_DIV: begin
                    if (w_bet == 0 && r_err == StOk) r_err <= StZeroLater;
                    r_dnum <= qsub(r_r, w_pq);
                    r_dden <= {2'b0, w_bet[31] ? -w_bet : w_bet} << 1;
                    r_dzero <= (w_bet == 0);
                    r_pivot <= w_bet;
                    r_j <= w_cidx;
                    r_ret <= S_IDLE;
                    r_dcnt <= 6'd63;
                    r_state <= S_DIVW;
                end
                S_ERR: begin
                    o_valid <= 1'b1;
                    o_data.solution <= '0;
                    o_data.row_index <= '0;
                    o_data.status <= r_err;
                    o_data.last_result <= 1'b1;
                    r_state <= S_OUT;
                end
                S_B_RD: begin
                    // r_j = row whose u is updated; needs u[j+1]
                    if (r_j == AW'(r_count - CW'(1))) begin
                        r_state <= S_OUT_RD;
                    end else begin
                        r_state <= S_B_MUL;
                    end
                end
                S_B_MUL: begin
                    r_state <= S_B_WR;
                end
                S_B_WR: begin
                    // u[j] - gamma[j+1] * u[j+1] goes straight to the output.
                    o_valid <= 1'b1;
                    o_data.solution <= qsub(r_u_rd, w_pq);
                    o_data.row_index <= 6'(r_j);
                    o_data.status <= r_err;
                    o_data.last_result <= (r_j == '0);
                    r_state <= S_OUT;
                end
                S_OUT_RD: begin
                    r_state <= S_OUT;
                    o_valid <= 1'b1;
                    o_data.solution <= r_u_rd;
                    o_data.row_index <= 6'(r_j);
                    o_data.status <= r_err;
                    o_data.last_result <= (r_j == '0);
                end
                S_OUT: if (i_ready) begin
                    o_valid <= 1'b0;
                    if (o_data.last_result) begin
                        r_state <= S_IDLE;
                        r_count <= '0;
                        r_err <= StOk;
                        r_pivot <= '0;
                        r_prev_super <= '0;
                    end else begin
                        // The word just delivered is u[j+1] for the next row.
                        r_unext <= o_data.solution;
                        r_j <= r_j - AW'(1);
                        r_state <= S_B_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        if (r_dzero) begin
            if (r_dnum > 0) w_dres = 32'sh7FFFFFFF;
            else if (r_dnum < 0) w_dres = 32'sh80000000;
            else w_dres = '0;
        end else w_dres = w_qsat;
    end
endmodule
`default_nettype wire
